// ===== hw/rtl/tmc_pkg.sv =====
// Shared constants and types for the thermostat menu controller.
`timescale 1ns / 1ps

package tmc_pkg;

    localparam int ADC_BITS   = 10;
    localparam int TIMER_BITS = 8;
    localparam int WAIT_BITS  = 8;
    localparam int LIMIT_BITS = 7;
    localparam int MENU_BITS  = 3;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = WAIT_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_BUTTON_WAIT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BACK_WAIT   = 1'd1;

    localparam logic [WAIT_BITS-1:0] BUTTON_WAIT_RST = 8'd29;
    localparam logic [WAIT_BITS-1:0] BACK_WAIT_RST   = 8'd5;

    localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = 7'd99;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Full scale: 1023 counts equal 500 degrees
    localparam int FULL_SCALE_DEG = 500;
    localparam int FULL_SCALE_CNT = 1023;
    localparam int SCALED_BITS = (ADC_BITS + 9 > LIMIT_BITS + 10) ? ADC_BITS + 9
                                                                  : LIMIT_BITS + 10;

    typedef struct packed {
        logic                  relay_high;
        logic                  relay_low;
        logic [MENU_BITS-1:0]  menu_state;
        logic [LIMIT_BITS-1:0] high_setpoint;
        logic [LIMIT_BITS-1:0] low_setpoint;
        logic                  screen_clear;
    } t_result;

endpackage

// ===== hw/rtl/tmc_tick_if.sv =====
// Input channel: one tick carrying button levels and a temperature sample.
`timescale 1ns / 1ps

interface tmc_tick_if;
    import tmc_pkg::*;

    logic                valid;
    logic                ready;
    logic                up_button_n;
    logic                down_button_n;
    logic                back_button_n;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (
        output valid, up_button_n, down_button_n, back_button_n, adc_sample,
        input  ready
    );
    modport sink (
        input  valid, up_button_n, down_button_n, back_button_n, adc_sample,
        output ready
    );
endinterface

// ===== hw/rtl/tmc_result_if.sv =====
// Output channel: relay drives, menu state and setpoints after each tick.
`timescale 1ns / 1ps

interface tmc_result_if;
    import tmc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  relay_high;
    logic                  relay_low;
    logic [MENU_BITS-1:0]  menu_state;
    logic [LIMIT_BITS-1:0] high_setpoint;
    logic [LIMIT_BITS-1:0] low_setpoint;
    logic                  screen_clear;

    modport source (
        output valid, relay_high, relay_low, menu_state, high_setpoint,
               low_setpoint, screen_clear,
        input  ready
    );
    modport sink (
        input  valid, relay_high, relay_low, menu_state, high_setpoint,
               low_setpoint, screen_clear,
        output ready
    );
endinterface

// ===== hw/rtl/tmc_button.sv =====
// Button qualifier: press flag and saturating tick timer for one button.
`timescale 1ns / 1ps

module tmc_button (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_check,
    input  logic                           i_pressed,
    input  logic [tmc_pkg::WAIT_BITS-1:0]  i_wait,
    output logic                           o_fire
);
    import tmc_pkg::*;

    logic                  r_flag;
    logic [TIMER_BITS-1:0] r_timer;
    logic                  n_flag;
    logic [TIMER_BITS-1:0] n_timer;
    logic [TIMER_BITS-1:0] w_timer_inc;
    logic                  w_expired;

    assign w_timer_inc = (r_timer == TIMER_MAX) ? r_timer : r_timer + 1'b1;
    // Timer and wait are compared at the sum of the two widths
    assign w_expired = ((TIMER_BITS + WAIT_BITS)'(w_timer_inc) >
                        (TIMER_BITS + WAIT_BITS)'(i_wait));

    always_comb begin
        n_flag  = r_flag;
        n_timer = w_timer_inc;
        o_fire  = 1'b0;
        if (i_check) begin
            if (!r_flag) begin
                if (i_pressed) begin
                    n_flag  = 1'b1;
                    n_timer = '0;
                end
            end else if (w_expired) begin
                if (i_pressed) begin
                    n_timer = '0;
                end else begin
                    n_flag = 1'b0;
                    o_fire = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= 1'b0;
            r_timer <= '0;
        end else if (i_step) begin
            r_flag  <= n_flag;
            r_timer <= n_timer;
        end
    end
endmodule

// ===== hw/rtl/thermostat_menu_controller.sv =====
// Top level: menu sequencer, setpoints, relay compare and result queue.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-----------------------------------------
//  i_tick    | in  | valid/ready        | up/down/back button levels, adc_sample
//  o_result  | out | valid/ready        | relays, menu_state, setpoints, clear
//  i_cfg_*   | in  | write enable only  | index 0 button_wait, 1 back_wait
//
// One tick per cycle while i_tick.ready is high: a tick is processed in the cycle it
// is accepted; its result is registered into the output register, or the skid if full.
// A two-entry result queue (output register plus skid) keeps i_tick.ready high
// while one result waits; ready drops only when both entries are full.
// Synchronous active-low reset clears menu, buttons, setpoints, relays, queue.
`timescale 1ns / 1ps

module thermostat_menu_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    tmc_tick_if.sink                           i_tick,
    tmc_result_if.source                       o_result,
    input  logic                               i_cfg_we,
    input  logic [tmc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [tmc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import tmc_pkg::*;

    typedef enum logic [MENU_BITS-1:0] {
        M_MAIN      = 3'd0,
        M_TEMP      = 3'd1,
        M_SETPOINTS = 3'd2,
        M_EDIT_HIGH = 3'd3,
        M_EDIT_LOW  = 3'd4
    } t_menu;

    t_menu                 r_menu, n_menu;
    logic [LIMIT_BITS-1:0] r_high, n_high;
    logic [LIMIT_BITS-1:0] r_low, n_low;
    logic                  r_relay_high, n_relay_high;
    logic                  r_relay_low, n_relay_low;
    logic                  n_clear;
    logic [WAIT_BITS-1:0]  r_button_wait;
    logic [WAIT_BITS-1:0]  r_back_wait;

    t_result               r_out, r_skid, n_result;
    logic                  r_out_v, r_skid_v;

    logic                  w_accept, w_pop;
    logic                  w_chk_up, w_chk_down, w_chk_back;
    logic                  w_fire_up, w_fire_down, w_fire_back;
    logic [SCALED_BITS-1:0] w_scaled, w_high_scaled, w_low_scaled;
    logic [LIMIT_BITS-1:0] w_lim;

    assign i_tick.ready = !r_skid_v;
    assign w_accept     = i_tick.valid && !r_skid_v;
    assign w_pop        = r_out_v && o_result.ready;

    // Which buttons the current menu listens to
    always_comb begin
        w_chk_up   = 1'b1;
        w_chk_down = 1'b1;
        w_chk_back = 1'b1;
        case (r_menu)
            M_TEMP: begin
                w_chk_up   = 1'b0;
                w_chk_down = 1'b0;
            end
            M_SETPOINTS, M_EDIT_HIGH, M_EDIT_LOW: begin
            end
            default: begin
                w_chk_back = 1'b0;
            end
        endcase
    end

    tmc_button u_btn_up (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_accept),
        .i_check   (w_chk_up),
        .i_pressed (!i_tick.up_button_n),
        .i_wait    (r_button_wait),
        .o_fire    (w_fire_up)
    );

    tmc_button u_btn_down (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_accept),
        .i_check   (w_chk_down),
        .i_pressed (!i_tick.down_button_n),
        .i_wait    (r_button_wait),
        .o_fire    (w_fire_down)
    );

    tmc_button u_btn_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_accept),
        .i_check   (w_chk_back),
        .i_pressed (!i_tick.back_button_n),
        .i_wait    (r_back_wait),
        .o_fire    (w_fire_back)
    );

    // sample*500 against limit*1023, exact integer compare
    assign w_scaled      = SCALED_BITS'(i_tick.adc_sample) * SCALED_BITS'(FULL_SCALE_DEG);
    assign w_high_scaled = SCALED_BITS'(r_high) * SCALED_BITS'(FULL_SCALE_CNT);
    assign w_low_scaled  = SCALED_BITS'(r_low) * SCALED_BITS'(FULL_SCALE_CNT);

    always_comb begin
        n_menu       = r_menu;
        n_high       = r_high;
        n_low        = r_low;
        n_relay_high = r_relay_high;
        n_relay_low  = r_relay_low;
        n_clear      = 1'b0;
        w_lim        = (r_menu == M_EDIT_HIGH) ? r_high : r_low;
        case (r_menu)
            M_TEMP: begin
                n_relay_high = 1'b0;
                n_relay_low  = 1'b0;
                if (r_high != '0 && w_scaled > w_high_scaled) begin
                    n_relay_high = 1'b1;
                end else if (r_low != '0 && w_scaled < w_low_scaled) begin
                    n_relay_low = 1'b1;
                end
                if (w_fire_back) begin
                    n_menu  = M_MAIN;
                    n_clear = 1'b1;
                end
            end
            M_SETPOINTS: begin
                // later buttons override earlier ones
                if (w_fire_up) begin
                    n_menu  = M_EDIT_HIGH;
                    n_clear = 1'b1;
                end
                if (w_fire_down) begin
                    n_menu  = M_EDIT_LOW;
                    n_clear = 1'b1;
                end
                if (w_fire_back) begin
                    n_menu  = M_MAIN;
                    n_clear = 1'b1;
                end
            end
            M_EDIT_HIGH, M_EDIT_LOW: begin
                if (w_fire_up) begin
                    w_lim = (w_lim >= LIMIT_MAX) ? LIMIT_MAX : w_lim + 1'b1;
                end
                if (w_fire_down) begin
                    w_lim = (w_lim == '0) ? '0 : w_lim - 1'b1;
                end
                if (r_menu == M_EDIT_HIGH) begin
                    n_high = w_lim;
                end else begin
                    n_low = w_lim;
                end
                if (w_fire_back) begin
                    n_menu  = M_SETPOINTS;
                    n_clear = 1'b1;
                end
            end
            default: begin
                n_menu = M_MAIN;
                if (w_fire_up) begin
                    n_menu  = M_TEMP;
                    n_clear = 1'b1;
                end
                if (w_fire_down) begin
                    n_menu  = M_SETPOINTS;
                    n_clear = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        n_result.relay_high    = n_relay_high;
        n_result.relay_low     = n_relay_low;
        n_result.menu_state    = n_menu;
        n_result.high_setpoint = n_high;
        n_result.low_setpoint  = n_low;
        n_result.screen_clear  = n_clear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_menu        <= M_MAIN;
            r_high        <= '0;
            r_low         <= '0;
            r_relay_high  <= 1'b0;
            r_relay_low   <= 1'b0;
            r_button_wait <= BUTTON_WAIT_RST;
            r_back_wait   <= BACK_WAIT_RST;
        end else begin
            if (w_accept) begin
                r_menu       <= n_menu;
                r_high       <= n_high;
                r_low        <= n_low;
                r_relay_high <= n_relay_high;
                r_relay_low  <= n_relay_low;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BUTTON_WAIT: r_button_wait <= i_cfg_data;
                    REG_BACK_WAIT:   r_back_wait   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result queue: output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_accept && (!r_out_v || w_pop)) begin
                r_out_v <= 1'b1;
            end else if (w_accept) begin
                r_skid_v <= 1'b1;
            end else if (w_pop) begin
                r_out_v  <= r_skid_v;
                r_skid_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (!r_out_v || w_pop)) begin
            r_out <= n_result;
        end else if (w_accept) begin
            r_skid <= n_result;
        end else if (w_pop && r_skid_v) begin
            r_out <= r_skid;
        end
    end

    assign o_result.valid         = r_out_v;
    assign o_result.relay_high    = r_out.relay_high;
    assign o_result.relay_low     = r_out.relay_low;
    assign o_result.menu_state    = r_out.menu_state;
    assign o_result.high_setpoint = r_out.high_setpoint;
    assign o_result.low_setpoint  = r_out.low_setpoint;
    assign o_result.screen_clear  = r_out.screen_clear;
endmodule

// ===== tb/sv/thermostat_menu_controller_tb.sv =====
// Self-checking testbench for the thermostat menu controller: button sequences in, status out.
`timescale 1ns / 1ps

module thermostat_menu_controller_tb;
    import tmc_pkg::*;

    localparam logic [MENU_BITS-1:0] MENU_MAIN      = 3'd0;
    localparam logic [MENU_BITS-1:0] MENU_TEMP      = 3'd1;
    localparam logic [MENU_BITS-1:0] MENU_SETPOINTS = 3'd2;
    localparam logic [MENU_BITS-1:0] MENU_EDIT_HIGH = 3'd3;
    localparam logic [MENU_BITS-1:0] MENU_EDIT_LOW  = 3'd4;

    localparam int BTN_UP   = 0;
    localparam int BTN_DOWN = 1;
    localparam int BTN_BACK = 2;

    localparam int unsigned IDLE_MAX       = 16;
    localparam int unsigned HOLD_OFF       = 200;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    tmc_tick_if   tick_ch ();
    tmc_result_if status_ch ();

    thermostat_menu_controller u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick_ch),
        .o_result   (status_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the controller state
    logic [WAIT_BITS-1:0]  m_button_wait;
    logic [WAIT_BITS-1:0]  m_back_wait;
    logic [MENU_BITS-1:0]  m_menu;
    logic                  m_flag [3];
    logic [TIMER_BITS-1:0] m_timer [3];
    logic [LIMIT_BITS-1:0] m_high;
    logic [LIMIT_BITS-1:0] m_low;
    logic                  m_relay_high;
    logic                  m_relay_low;

    t_result     pending_status [$];
    int unsigned mismatches;
    int unsigned ticks_sent;
    int unsigned tx_idle_max;
    int unsigned rx_idle_max;
    int unsigned hold_len;
    int unsigned idle_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Press qualification: returns 1 when the button fires on this tick
    function automatic logic button_fires(input int b, input logic pressed,
                                          input logic [WAIT_BITS-1:0] wt);
        if (!m_flag[b]) begin
            if (pressed) begin
                m_flag[b]  = 1'b1;
                m_timer[b] = '0;
            end
            return 1'b0;
        end
        if (m_timer[b] > wt) begin
            if (pressed) begin
                m_timer[b] = '0;
                return 1'b0;
            end
            m_flag[b] = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic advance_thermostat(input logic up_n, dn_n, bk_n,
                                      input logic [ADC_BITS-1:0] adc);
        logic                  up, dn, bk, clear;
        logic [LIMIT_BITS-1:0] lim;
        int                    scaled;
        int                    i;
        t_result               st;
        up    = !up_n;
        dn    = !dn_n;
        bk    = !bk_n;
        clear = 1'b0;
        for (i = 0; i < 3; i++)
            if (m_timer[i] != TIMER_MAX) m_timer[i] = m_timer[i] + 1'b1;

        case (m_menu)
            MENU_TEMP: begin
                scaled = int'(adc) * FULL_SCALE_DEG;
                if (m_high != '0 && scaled > int'(m_high) * FULL_SCALE_CNT) begin
                    m_relay_high = 1'b1;
                    m_relay_low  = 1'b0;
                end else if (m_low != '0 && scaled < int'(m_low) * FULL_SCALE_CNT) begin
                    m_relay_high = 1'b0;
                    m_relay_low  = 1'b1;
                end else begin
                    m_relay_high = 1'b0;
                    m_relay_low  = 1'b0;
                end
                if (button_fires(BTN_BACK, bk, m_back_wait)) begin
                    m_menu = MENU_MAIN;
                    clear  = 1'b1;
                end
            end
            MENU_SETPOINTS: begin
                if (button_fires(BTN_UP, up, m_button_wait)) begin
                    m_menu = MENU_EDIT_HIGH;
                    clear  = 1'b1;
                end
                if (button_fires(BTN_DOWN, dn, m_button_wait)) begin
                    m_menu = MENU_EDIT_LOW;
                    clear  = 1'b1;
                end
                if (button_fires(BTN_BACK, bk, m_back_wait)) begin
                    m_menu = MENU_MAIN;
                    clear  = 1'b1;
                end
            end
            MENU_EDIT_HIGH, MENU_EDIT_LOW: begin
                lim = (m_menu == MENU_EDIT_HIGH) ? m_high : m_low;
                if (button_fires(BTN_UP, up, m_button_wait))
                    lim = (lim >= LIMIT_MAX) ? LIMIT_MAX : lim + 1'b1;
                if (button_fires(BTN_DOWN, dn, m_button_wait))
                    lim = (lim == '0) ? '0 : lim - 1'b1;
                if (m_menu == MENU_EDIT_HIGH) m_high = lim;
                else m_low = lim;
                if (button_fires(BTN_BACK, bk, m_back_wait)) begin
                    m_menu = MENU_SETPOINTS;
                    clear  = 1'b1;
                end
            end
            default: begin
                m_menu = MENU_MAIN;
                if (button_fires(BTN_UP, up, m_button_wait)) begin
                    m_menu = MENU_TEMP;
                    clear  = 1'b1;
                end
                if (button_fires(BTN_DOWN, dn, m_button_wait)) begin
                    m_menu = MENU_SETPOINTS;
                    clear  = 1'b1;
                end
            end
        endcase

        st.relay_high    = m_relay_high;
        st.relay_low     = m_relay_low;
        st.menu_state    = m_menu;
        st.high_setpoint = m_high;
        st.low_setpoint  = m_low;
        st.screen_clear  = clear;
        pending_status.push_back(st);
    endtask

    // Samples around the current setpoint thresholds, uniform random samples, plus the rails
    function automatic logic [ADC_BITS-1:0] pick_sample();
        int unsigned r;
        int          lvl;
        r = $urandom_range(9, 0);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 6) begin
            lvl = int'(($urandom_range(1, 0) != 0) ? m_high : m_low) * FULL_SCALE_CNT
                  / FULL_SCALE_DEG + int'($urandom_range(2, 0)) - 1;
            if (lvl < 0) lvl = 0;
            if (lvl > (1 << ADC_BITS) - 1) lvl = (1 << ADC_BITS) - 1;
            return lvl[ADC_BITS-1:0];
        end
        return ADC_BITS'($urandom_range((1 << ADC_BITS) - 1, 0));
    endfunction

    task automatic send_tick(input logic up_n, dn_n, bk_n, input logic [ADC_BITS-1:0] adc);
        int unsigned gap;
        gap = (tx_idle_max == 0) ? 0 : $urandom_range(tx_idle_max, 0);
        @(negedge i_clk);
        if (gap != 0) begin
            tick_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_ch.valid         = 1'b1;
        tick_ch.up_button_n   = up_n;
        tick_ch.down_button_n = dn_n;
        tick_ch.back_button_n = bk_n;
        tick_ch.adc_sample    = adc;
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
        advance_thermostat(up_n, dn_n, bk_n, adc);
        ticks_sent++;
    endtask

    task automatic send_noise();
        send_tick(1'($urandom), 1'($urandom), 1'($urandom), pick_sample());
    endtask

    // Hold the given buttons for some ticks, then release for some ticks
    task automatic press(input logic up, dn, bk, input int unsigned hold, gap_ticks);
        repeat (hold) send_tick(!up, !dn, !bk, pick_sample());
        repeat (gap_ticks) send_tick(1'b1, 1'b1, 1'b1, pick_sample());
    endtask

    task automatic drain_status();
        @(negedge i_clk);
        tick_ch.valid = 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == REG_BUTTON_WAIT) m_button_wait = data;
        else m_back_wait = data;
    endtask

    task automatic apply_waits(input logic [WAIT_BITS-1:0] bw, kw);
        drain_status();
        write_reg(REG_BUTTON_WAIT, bw);
        write_reg(REG_BACK_WAIT, kw);
    endtask

    // Reset waits: up needs more than 29 ticks, back more than 5
    task automatic test_reset_waits();
        press(1'b1, 1'b0, 1'b0, 20, 12);
        send_tick(1'b1, 1'b1, 1'b1, '0);
        send_tick(1'b1, 1'b1, 1'b1, '1);
        press(1'b0, 1'b0, 1'b1, 2, 6);
    endtask

    // Zero waits: a press and a release fire in two ticks
    task automatic test_menu_walk();
        apply_waits('0, '0);
        press(1'b0, 1'b1, 1'b0, 1, 1);
        press(1'b1, 1'b0, 1'b0, 1, 1);
        press(1'b0, 1'b1, 1'b0, 1, 1);     // decrement held at zero
        press(1'b1, 1'b0, 1'b0, 1, 1);
        press(1'b1, 1'b1, 1'b0, 1, 1);     // increment and decrement together
        press(1'b0, 1'b0, 1'b1, 1, 1);
        press(1'b0, 1'b1, 1'b0, 1, 1);
        press(1'b1, 1'b0, 1'b0, 1, 1);
        press(1'b0, 1'b0, 1'b1, 1, 1);
        press(1'b1, 1'b1, 1'b1, 1, 1);     // all three fire, back wins
        press(1'b1, 1'b0, 1'b0, 1, 1);
        // both limits at 1: low below 3, high from 3, high wins where both hold
        send_tick(1'b1, 1'b1, 1'b1, 10'd0);
        send_tick(1'b1, 1'b1, 1'b1, 10'd2);
        send_tick(1'b1, 1'b1, 1'b1, 10'd3);
        send_tick(1'b1, 1'b1, 1'b1, '1);
        press(1'b1, 1'b1, 1'b0, 1, 1);     // not checked in the temperature view
        press(1'b0, 1'b0, 1'b1, 1, 1);
    endtask

    task automatic test_limit_saturation();
        apply_waits('0, '0);
        press(1'b0, 1'b1, 1'b0, 1, 1);
        press(1'b1, 1'b0, 1'b0, 1, 1);
        repeat (100) press(1'b1, 1'b0, 1'b0, 1, 1);
    endtask

    // Widest waits: the timer has to saturate before the release counts
    task automatic test_long_wait();
        apply_waits(8'd254, 8'd254);
        press(1'b0, 1'b1, 1'b0, 5, 252);
    endtask

    task automatic test_random_menu(input int unsigned n_ticks,
                                    input logic [WAIT_BITS-1:0] bw, kw,
                                    input int unsigned tx_max, rx_max);
        int unsigned stop_at, r, wt;
        logic [2:0]  btn;      // {back, down, up}
        apply_waits(bw, kw);
        tx_idle_max = tx_max;
        rx_idle_max = rx_max;
        stop_at     = ticks_sent + n_ticks;
        while (ticks_sent < stop_at) begin
            r = $urandom_range(99, 0);
            if (r < 8) begin
                repeat ($urandom_range(4, 1)) send_noise();
                continue;
            end
            case (m_menu)
                MENU_MAIN:
                    btn = (r < 55) ? 3'b001 : (r < 95) ? 3'b010 : 3'b011;
                MENU_TEMP: begin
                    if (r < 70) begin
                        repeat ($urandom_range(6, 1)) send_tick(1'b1, 1'b1, 1'b1, pick_sample());
                        continue;
                    end
                    btn = (r < 92) ? 3'b100 : 3'($urandom_range(7, 1));
                end
                MENU_SETPOINTS:
                    btn = (r < 45) ? 3'b001 : (r < 80) ? 3'b010 : (r < 94) ? 3'b100
                                                                         : 3'($urandom_range(7, 1));
                default:
                    btn = (r < 62) ? 3'b001 : (r < 86) ? 3'b010 : (r < 95) ? 3'b100
                                                                         : 3'($urandom_range(7, 1));
            endcase
            wt = (btn == 3'b100) ? m_back_wait : m_button_wait;
            press(btn[0], btn[1], btn[2], $urandom_range(wt + 3, 1),
                  $urandom_range(wt + 2, (wt + 2) / 2));
        end
        tx_idle_max = IDLE_MAX;
        rx_idle_max = IDLE_MAX;
    endtask

    // Receiver holds off while ticks keep coming, so the result queue fills
    task automatic test_backpressure();
        drain_status();
        tx_idle_max = 0;
        hold_len    = HOLD_OFF;
        repeat (40) send_noise();
        tx_idle_max = IDLE_MAX;
    endtask

    always begin : status_sink
        int unsigned pause;
        @(negedge i_clk);
        if (hold_len != 0) begin
            pause    = hold_len;
            hold_len = 0;
        end else begin
            pause = (rx_idle_max == 0) ? 0 : $urandom_range(rx_idle_max, 0);
        end
        if (pause != 0) begin
            status_ch.ready = 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        status_ch.ready = 1'b1;
        do @(posedge i_clk); while (!(i_rst_n && status_ch.valid === 1'b1));
    end

    always @(posedge i_clk) begin : status_check
        t_result want;
        if (i_rst_n && status_ch.valid === 1'b1 && status_ch.ready === 1'b1) begin
            if (pending_status.size() == 0) begin
                report_mismatch("status with no tick pending", 1, 0);
            end else begin
                want = pending_status.pop_front();
                if (status_ch.relay_high !== want.relay_high)
                    report_mismatch("relay_high", status_ch.relay_high, want.relay_high);
                if (status_ch.relay_low !== want.relay_low)
                    report_mismatch("relay_low", status_ch.relay_low, want.relay_low);
                if (status_ch.menu_state !== want.menu_state)
                    report_mismatch("menu_state", status_ch.menu_state, want.menu_state);
                if (status_ch.high_setpoint !== want.high_setpoint)
                    report_mismatch("high_setpoint", status_ch.high_setpoint,
                                    want.high_setpoint);
                if (status_ch.low_setpoint !== want.low_setpoint)
                    report_mismatch("low_setpoint", status_ch.low_setpoint, want.low_setpoint);
                if (status_ch.screen_clear !== want.screen_clear)
                    report_mismatch("screen_clear", status_ch.screen_clear, want.screen_clear);
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1)
                     || (status_ch.valid === 1'b1 && status_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        tick_ch.valid         = 1'b0;
        tick_ch.up_button_n   = 1'b1;
        tick_ch.down_button_n = 1'b1;
        tick_ch.back_button_n = 1'b1;
        tick_ch.adc_sample    = '0;
        status_ch.ready       = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = REG_BUTTON_WAIT;
        cfg_data              = '0;
        tx_idle_max           = IDLE_MAX;
        rx_idle_max           = IDLE_MAX;
        hold_len              = 0;
        mismatches            = 0;
        ticks_sent            = 0;

        m_button_wait = BUTTON_WAIT_RST;
        m_back_wait   = BACK_WAIT_RST;
        m_menu        = MENU_MAIN;
        for (int i = 0; i < 3; i++) begin
            m_flag[i]  = 1'b0;
            m_timer[i] = '0;
        end
        m_high       = '0;
        m_low        = '0;
        m_relay_high = 1'b0;
        m_relay_low  = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_waits();
        test_menu_walk();
        test_limit_saturation();
        test_long_wait();
        test_random_menu(80, 8'd2, 8'd1, IDLE_MAX, IDLE_MAX);
        test_random_menu(50, 8'd0, 8'd7, 0, 0);
        test_random_menu(50, 8'd1, 8'd3, IDLE_MAX, 0);
        test_random_menu(60, BUTTON_WAIT_RST, BACK_WAIT_RST, 0, IDLE_MAX);
        test_backpressure();

        drain_status();
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
